FILE: hdl/tmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_pkg
// Types, codes and constants shared by the tree membership block.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam logic [7:0] ORPHAN_LEVEL = 8'd255;
  localparam logic [7:0] MAX_CHECKS_RESET = 8'd5;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Request kinds.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_BCAST = 2'd1;
  localparam logic [1:0] REQ_UCAST = 2'd2;

  // Message classes.
  localparam logic [7:0] CLASS_TREE = 8'd0;
  localparam logic [7:0] CLASS_SENSOR = 8'd1;

  // Tree codes.
  localparam logic [7:0] CODE_ORPHAN_REQ = 8'd0;
  localparam logic [7:0] CODE_OFFER = 8'd1;
  localparam logic [7:0] CODE_CHECK = 8'd2;
  localparam logic [7:0] CODE_UPDATE = 8'd3;
  localparam logic [7:0] CODE_ORPHAN = 8'd4;

  // Message lengths.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_CHECK = 3'd3;
  localparam logic [2:0] LEN_SENSOR = 3'd4;
  localparam logic [2:0] LEN_FULL = 3'd5;

  typedef struct packed {
    logic        member;
    logic [7:0]  level;
    logic        periodic;
    logic        forward;
    logic [7:0]  count;
    logic [15:0] parent;
  } node_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] src_addr;
    logic [7:0]  in_byte0;
    logic [7:0]  in_byte1;
    logic [7:0]  in_byte2;
    logic [7:0]  in_byte3;
    logic [7:0]  in_byte4;
  } item_t;

  typedef struct packed {
    logic        msg_valid;
    logic        msg_broadcast;
    logic [15:0] dest_addr;
    logic [2:0]  msg_len;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [7:0]  out_byte4;
    logic        in_tree;
    logic [7:0]  tree_level;
  } result_t;

endpackage

FILE: hdl/tmp_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_decide
// Decision logic: from the node state and one item, the next state and the
// message to send.
// ----------------------------------------------------------------------------
module tmp_decide (
  input  tmp_pkg::node_state_t st,
  input  tmp_pkg::item_t       item,
  input  logic [7:0]           max_checks,
  output tmp_pkg::node_state_t st_next,
  output tmp_pkg::result_t     res
);

  logic [7:0] count_inc;
  logic [8:0] offer_level;

  assign count_inc = (st.count < tmp_pkg::COUNT_MAX) ? st.count + 8'd1 : st.count;
  assign offer_level = {1'b0, item.in_byte2} + 9'd1;

  always_comb begin
    st_next = st;
    res = '0;
    unique case (item.req_type)
      tmp_pkg::REQ_TICK: begin
        res.msg_valid = 1'b1;
        if (!st.member) begin
          res.msg_broadcast = 1'b1;
          res.msg_len = tmp_pkg::LEN_SHORT;
          res.out_byte1 = tmp_pkg::CODE_ORPHAN_REQ;
        end else begin
          res.dest_addr = st.parent;
          res.msg_len = tmp_pkg::LEN_CHECK;
          res.out_byte1 = tmp_pkg::CODE_CHECK;
          res.out_byte2 = st.level;
          st_next.count = count_inc;
          if (count_inc >= max_checks) begin
            st_next.member = 1'b0;
            st_next.level = tmp_pkg::ORPHAN_LEVEL;
            st_next.count = '0;
            st_next.periodic = 1'b1;
            st_next.forward = 1'b0;
          end
        end
      end
      tmp_pkg::REQ_BCAST: begin
        if (st.member) begin
          res.msg_valid = 1'b1;
          res.dest_addr = item.src_addr;
          res.msg_len = tmp_pkg::LEN_FULL;
          res.out_byte1 = tmp_pkg::CODE_OFFER;
          res.out_byte2 = st.level;
          res.out_byte3 = {7'd0, st.periodic};
          res.out_byte4 = {7'd0, st.forward};
        end
      end
      tmp_pkg::REQ_UCAST: begin
        if (item.in_byte0 == tmp_pkg::CLASS_TREE) begin
          unique case (item.in_byte1)
            tmp_pkg::CODE_OFFER: begin
              if (offer_level < {1'b0, st.level}) begin
                st_next.parent = item.src_addr;
                st_next.member = 1'b1;
                st_next.level = offer_level[7:0];
                st_next.periodic = (item.in_byte3 != 8'd0);
                st_next.forward = (item.in_byte4 != 8'd0);
              end
            end
            tmp_pkg::CODE_CHECK: begin
              res.msg_valid = 1'b1;
              res.dest_addr = item.src_addr;
              if (st.member && (item.in_byte2 > st.level)) begin
                res.msg_len = tmp_pkg::LEN_FULL;
                res.out_byte1 = tmp_pkg::CODE_UPDATE;
                res.out_byte2 = st.level;
                res.out_byte3 = {7'd0, st.periodic};
                res.out_byte4 = {7'd0, st.forward};
              end else begin
                res.msg_len = tmp_pkg::LEN_SHORT;
                res.out_byte1 = tmp_pkg::CODE_ORPHAN;
              end
            end
            tmp_pkg::CODE_UPDATE: begin
              // The level saturates at the orphan level.
              st_next.level = (item.in_byte2 == tmp_pkg::ORPHAN_LEVEL) ?
                              tmp_pkg::ORPHAN_LEVEL : offer_level[7:0];
              st_next.periodic = (item.in_byte3 != 8'd0);
              st_next.forward = (item.in_byte4 != 8'd0);
              st_next.count = '0;
            end
            tmp_pkg::CODE_ORPHAN: begin
              if (st.member) begin
                st_next.member = 1'b0;
                st_next.level = tmp_pkg::ORPHAN_LEVEL;
                st_next.count = '0;
                st_next.periodic = 1'b1;
                st_next.forward = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end else if (item.in_byte0 == tmp_pkg::CLASS_SENSOR) begin
          if (st.forward) begin
            res.msg_valid = 1'b1;
            res.dest_addr = st.parent;
            res.msg_len = tmp_pkg::LEN_SENSOR;
            res.out_byte0 = item.in_byte0;
            res.out_byte1 = item.in_byte1;
            res.out_byte2 = item.in_byte2;
            res.out_byte3 = item.in_byte3;
          end
        end
      end
      default: begin
      end
    endcase
    res.in_tree = st_next.member;
    res.tree_level = st_next.level;
  end

endmodule

FILE: hdl/tree_membership_protocol.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_membership_protocol
// Keeps a node's place in a routing tree and builds the message for each
// tick, received broadcast or received unicast.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when            Payload
// s_axis    in         s_tvalid && s_tready     request item
// m_axis    out        m_tvalid && m_tready     one result per item
// cfg       in         cfg_valid && cfg_ready   max_checks
//
// An item is held in the input register, is decided against the node state
// and lands in the output register; one item is taken every cycle while the
// output is not stalled. The state is updated when the item moves to the
// output register, so each item sees all earlier ones. A stalled output holds
// its result and the input register holds one more item. Reset is
// synchronous; max_checks returns to 5 and the node to orphan.
// ----------------------------------------------------------------------------
module tree_membership_protocol (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] src_addr, [23:16] in_byte0, [31:24] in_byte1, [39:32] in_byte2,
  // [47:40] in_byte3, [55:48] in_byte4
  input  logic [55:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] dest_addr, [18:16] msg_len, [26:19] out_byte0, [34:27] out_byte1,
  // [42:35] out_byte2, [50:43] out_byte3, [58:51] out_byte4, [59] in_tree,
  // [67:60] tree_level, [71:68] zero
  output logic [71:0] m_tdata,
  // [0] msg_valid, [1] msg_broadcast
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                 in_valid;
  tmp_pkg::item_t       in_item;
  logic                 out_valid;
  tmp_pkg::result_t     out_res;
  tmp_pkg::node_state_t node;
  tmp_pkg::node_state_t node_next;
  tmp_pkg::result_t     res_next;
  logic [7:0]           max_checks;
  logic                 advance;

  assign advance = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  tmp_decide u_decide (
    .st         (node),
    .item       (in_item),
    .max_checks (max_checks),
    .st_next    (node_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      max_checks <= tmp_pkg::MAX_CHECKS_RESET;
      node.member <= 1'b0;
      node.level <= tmp_pkg::ORPHAN_LEVEL;
      node.periodic <= 1'b1;
      node.forward <= 1'b0;
      node.count <= '0;
      node.parent <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_checks <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        node <= node_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type <= s_tuser;
      in_item.src_addr <= s_tdata[15:0];
      in_item.in_byte0 <= s_tdata[23:16];
      in_item.in_byte1 <= s_tdata[31:24];
      in_item.in_byte2 <= s_tdata[39:32];
      in_item.in_byte3 <= s_tdata[47:40];
      in_item.in_byte4 <= s_tdata[55:48];
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser = {out_res.msg_broadcast, out_res.msg_valid};
  assign m_tdata = {4'd0, out_res.tree_level, out_res.in_tree, out_res.out_byte4,
                    out_res.out_byte3, out_res.out_byte2, out_res.out_byte1,
                    out_res.out_byte0, out_res.msg_len, out_res.dest_addr};

`ifndef SYNTHESIS
  // An orphan never carries a pending check count.
  a_orphan_count: assert property (@(posedge clk) disable iff (rst)
    !node.member |-> node.count == 8'd0)
    else $error("orphan node with nonzero check count");

  // A held input item must not be dropped or changed while the output stalls.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input register lost a waiting item");

  // A result without a message carries no length.
  a_no_msg_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.msg_valid |-> out_res.msg_len == tmp_pkg::LEN_NONE)
    else $error("empty result with nonzero length");
`endif

endmodule

FILE: sim/tree_membership_protocol_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_membership_protocol_tb
// Self-checking bench for the tree membership block. A queue of request items
// feeds a stream driver, and a behavioral node model predicts the message and
// membership for each accepted transfer. A monitor compares every output
// transfer field by field against the oldest prediction. The run covers
// directed corner cases first, then random protocol traffic under several
// max_checks settings, with random backpressure on both streams.
// ----------------------------------------------------------------------------
module tree_membership_protocol_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  tmp_pkg::item_t       rx_queue[$];
  tmp_pkg::result_t     expected_msgs[$];
  tmp_pkg::item_t       cur_item;
  tmp_pkg::node_state_t node;
  logic [7:0]           max_checks_q;
  logic                 steady = 1'b0;
  int unsigned          errors = 0;
  int unsigned          cycle_count = 0;

  tree_membership_protocol u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral node model.
  // ---------------------------------------------------------------------------
  function automatic void drop_to_orphan();
    node.member   = 1'b0;
    node.level    = tmp_pkg::ORPHAN_LEVEL;
    node.count    = '0;
    node.periodic = 1'b1;
    node.forward  = 1'b0;
  endfunction

  function automatic tmp_pkg::result_t node_reaction(tmp_pkg::item_t it);
    tmp_pkg::result_t r;
    r = '0;
    case (it.req_type)
      tmp_pkg::REQ_TICK: begin
        r.msg_valid = 1'b1;
        if (!node.member) begin
          r.msg_broadcast = 1'b1;
          r.msg_len       = tmp_pkg::LEN_SHORT;
          r.out_byte0     = tmp_pkg::CLASS_TREE;
          r.out_byte1     = tmp_pkg::CODE_ORPHAN_REQ;
        end else begin
          r.dest_addr = node.parent;
          r.msg_len   = tmp_pkg::LEN_CHECK;
          r.out_byte0 = tmp_pkg::CLASS_TREE;
          r.out_byte1 = tmp_pkg::CODE_CHECK;
          r.out_byte2 = node.level;
          if (node.count < tmp_pkg::COUNT_MAX) node.count = node.count + 8'd1;
          if (node.count >= max_checks_q) drop_to_orphan();
        end
      end
      tmp_pkg::REQ_BCAST: begin
        if (node.member) begin
          r.msg_valid = 1'b1;
          r.dest_addr = it.src_addr;
          r.msg_len   = tmp_pkg::LEN_FULL;
          r.out_byte0 = tmp_pkg::CLASS_TREE;
          r.out_byte1 = tmp_pkg::CODE_OFFER;
          r.out_byte2 = node.level;
          r.out_byte3 = {7'd0, node.periodic};
          r.out_byte4 = {7'd0, node.forward};
        end
      end
      tmp_pkg::REQ_UCAST: begin
        if (it.in_byte0 == tmp_pkg::CLASS_TREE) begin
          case (it.in_byte1)
            tmp_pkg::CODE_OFFER: begin
              // The offered level plus one must be strictly below our level.
              if ({1'b0, it.in_byte2} + 9'd1 < {1'b0, node.level}) begin
                node.parent   = it.src_addr;
                node.member   = 1'b1;
                node.level    = it.in_byte2 + 8'd1;
                node.periodic = (it.in_byte3 != 8'd0);
                node.forward  = (it.in_byte4 != 8'd0);
              end
            end
            tmp_pkg::CODE_CHECK: begin
              r.msg_valid = 1'b1;
              r.dest_addr = it.src_addr;
              r.out_byte0 = tmp_pkg::CLASS_TREE;
              if (node.member && it.in_byte2 > node.level) begin
                r.msg_len   = tmp_pkg::LEN_FULL;
                r.out_byte1 = tmp_pkg::CODE_UPDATE;
                r.out_byte2 = node.level;
                r.out_byte3 = {7'd0, node.periodic};
                r.out_byte4 = {7'd0, node.forward};
              end else begin
                r.msg_len   = tmp_pkg::LEN_SHORT;
                r.out_byte1 = tmp_pkg::CODE_ORPHAN;
              end
            end
            tmp_pkg::CODE_UPDATE: begin
              node.level    = (it.in_byte2 == 8'hFF) ? tmp_pkg::ORPHAN_LEVEL :
                              it.in_byte2 + 8'd1;
              node.periodic = (it.in_byte3 != 8'd0);
              node.forward  = (it.in_byte4 != 8'd0);
              node.count    = '0;
            end
            tmp_pkg::CODE_ORPHAN: begin
              if (node.member) drop_to_orphan();
            end
            default: ;
          endcase
        end else if (it.in_byte0 == tmp_pkg::CLASS_SENSOR) begin
          if (node.forward) begin
            r.msg_valid = 1'b1;
            r.dest_addr = node.parent;
            r.msg_len   = tmp_pkg::LEN_SENSOR;
            r.out_byte0 = it.in_byte0;
            r.out_byte1 = it.in_byte1;
            r.out_byte2 = it.in_byte2;
            r.out_byte3 = it.in_byte3;
          end
        end
      end
      default: ;
    endcase
    r.in_tree    = node.member;
    r.tree_level = node.level;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] req, input logic [15:0] src,
                           input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input logic [7:0] b4);
    tmp_pkg::item_t it;
    it = '{req_type: req, src_addr: src, in_byte0: b0, in_byte1: b1,
           in_byte2: b2, in_byte3: b3, in_byte4: b4};
    rx_queue.push_back(it);
  endtask

  function automatic logic [7:0] pick_level();
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'hFE;
      3, 4, 5, 6: return 8'($urandom_range(10));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    int unsigned k;
    k = $urandom_range(3);
    case (k)
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_addr();
    int unsigned k;
    k = $urandom_range(15);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // Mostly well-formed protocol traffic so that the node joins, ages and
  // leaves the tree often; about a tenth is malformed noise.
  task automatic push_random(input int unsigned count);
    int unsigned sel;
    logic [7:0]  junk;
    repeat (count) begin
      sel  = $urandom_range(99);
      junk = 8'($urandom_range(255));
      if (sel < 20) begin
        push_item(tmp_pkg::REQ_TICK, pick_addr(), junk, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end else if (sel < 33) begin
        push_item(tmp_pkg::REQ_BCAST, pick_addr(), junk, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end else if (sel < 48) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_TREE,
                  tmp_pkg::CODE_OFFER, pick_level(), pick_flag(), pick_flag());
      end else if (sel < 60) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_TREE,
                  tmp_pkg::CODE_CHECK, pick_level(),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (sel < 70) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_TREE,
                  tmp_pkg::CODE_UPDATE, pick_level(), pick_flag(), pick_flag());
      end else if (sel < 75) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_TREE,
                  tmp_pkg::CODE_ORPHAN, junk,
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (sel < 89) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_SENSOR,
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (sel < 93) begin
        push_item(REQ_UNUSED, pick_addr(), junk, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end else if (sel < 96) begin
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), 8'($urandom_range(2, 255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        junk = ($urandom_range(1) != 0) ? tmp_pkg::CODE_ORPHAN_REQ :
               8'($urandom_range(5, 255));
        push_item(tmp_pkg::REQ_UCAST, pick_addr(), tmp_pkg::CLASS_TREE, junk,
                  pick_level(), pick_flag(), pick_flag());
      end
    end
  endtask

  // Holds off until every queued request has been taken and answered.
  task automatic wait_idle();
    while (rx_queue.size() != 0 || s_tvalid || expected_msgs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_checks(input logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    max_checks_q = cfg_data;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request stream driver.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_msgs.push_back(node_reaction(cur_item));
      if (!s_tvalid || s_tready) begin
        if (rx_queue.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          cur_item = rx_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_item.in_byte4, cur_item.in_byte3, cur_item.in_byte2,
                       cur_item.in_byte1, cur_item.in_byte0, cur_item.src_addr};
          s_tuser  <= cur_item.req_type;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stream monitor.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want != got) begin
      $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tmp_pkg::result_t want;
    m_tready <= steady || ($urandom_range(99) >= 27);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_msgs.size() == 0) begin
        $display("%0t ns: unexpected result transfer, actual tdata 0x%0h tuser 0x%0h",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_msgs.pop_front();
        check_field("msg_valid", 16'(want.msg_valid), 16'(m_tuser[0]));
        check_field("msg_broadcast", 16'(want.msg_broadcast), 16'(m_tuser[1]));
        check_field("dest_addr", want.dest_addr, m_tdata[15:0]);
        check_field("msg_len", 16'(want.msg_len), 16'(m_tdata[18:16]));
        check_field("out_byte0", 16'(want.out_byte0), 16'(m_tdata[26:19]));
        check_field("out_byte1", 16'(want.out_byte1), 16'(m_tdata[34:27]));
        check_field("out_byte2", 16'(want.out_byte2), 16'(m_tdata[42:35]));
        check_field("out_byte3", 16'(want.out_byte3), 16'(m_tdata[50:43]));
        check_field("out_byte4", 16'(want.out_byte4), 16'(m_tdata[58:51]));
        check_field("in_tree", 16'(want.in_tree), 16'(m_tdata[59]));
        check_field("tree_level", 16'(want.tree_level), 16'(m_tdata[67:60]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tree_membership_protocol verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    max_checks_q = tmp_pkg::MAX_CHECKS_RESET;
    node.parent  = '0;
    drop_to_orphan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Orphan behavior, including an update and sensor forwarding while orphan.
    push_item(tmp_pkg::REQ_TICK, 16'h1234, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(tmp_pkg::REQ_BCAST, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0001, tmp_pkg::CLASS_SENSOR, 8'h11, 8'h22,
              8'h33, 8'h44);
    push_item(tmp_pkg::REQ_UCAST, 16'hBEEF, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_CHECK,
              8'hFF, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0002, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_ORPHAN,
              8'h00, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0003, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_UPDATE,
              8'd3, 8'h00, 8'h01);
    push_item(tmp_pkg::REQ_UCAST, 16'h0004, tmp_pkg::CLASS_SENSOR, 8'hFF, 8'hFF,
              8'hFF, 8'hFF);
    push_item(tmp_pkg::REQ_UCAST, 16'h0005, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_UPDATE,
              8'hFF, 8'h01, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0006, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_OFFER,
              8'hFF, 8'h01, 8'h01);
    // Join at level one, then try offers that cannot improve it.
    push_item(tmp_pkg::REQ_UCAST, 16'hFFFF, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_OFFER,
              8'd0, 8'hFF, 8'hFF);
    push_item(tmp_pkg::REQ_UCAST, 16'h0007, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_OFFER,
              8'd0, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_BCAST, 16'hA5A5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h5A5A, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_CHECK,
              8'd0, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h00FF, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_CHECK,
              8'hFF, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0008, tmp_pkg::CLASS_SENSOR, 8'hFF, 8'hFF,
              8'hFF, 8'hFF);
    // Unanswered checks until the node drops out of the tree.
    repeat (5) push_item(tmp_pkg::REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h0009, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_OFFER,
              8'd252, 8'h00, 8'h00);
    push_item(tmp_pkg::REQ_UCAST, 16'h000A, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_OFFER,
              8'd253, 8'h01, 8'h01);
    push_item(tmp_pkg::REQ_UCAST, 16'h000B, tmp_pkg::CLASS_TREE, tmp_pkg::CODE_ORPHAN,
              8'h00, 8'h00, 8'h00);
    // Malformed requests leave the node alone.
    push_item(REQ_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(tmp_pkg::REQ_UCAST, 16'h000C, 8'd2, tmp_pkg::CODE_OFFER, 8'd0, 8'h01,
              8'h01);
    push_item(tmp_pkg::REQ_UCAST, 16'h000D, tmp_pkg::CLASS_TREE, 8'd5, 8'd0, 8'h01,
              8'h01);
    push_item(tmp_pkg::REQ_UCAST, 16'h000E, tmp_pkg::CLASS_TREE,
              tmp_pkg::CODE_ORPHAN_REQ, 8'd0, 8'h01, 8'h01);
    push_item(tmp_pkg::REQ_UCAST, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    write_max_checks(8'hFF);
    push_random(300);
    write_max_checks(8'd1);
    push_random(250);
    // With a limit of zero every member tick drops the node.
    write_max_checks(8'd0);
    push_random(150);
    wait_idle();
    steady = 1'b1;
    write_max_checks(8'($urandom_range(2, 254)));
    push_random(400);
    wait_idle();
    steady = 1'b0;
    write_max_checks(tmp_pkg::MAX_CHECKS_RESET);
    push_random(400);

    wait_idle();
    if (errors == 0) begin
      $display("tree_membership_protocol verification clean");
    end else begin
      $display("tree_membership_protocol verification failed");
    end
    $finish;
  end

endmodule
